[hdl/csc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the three-stage charge controller.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int NUM_SAMPLES = 5;
	localparam int SAMPLE_W    = 10;
	localparam int CUR_W       = 14;
	localparam int DUTY_W      = 14;
	localparam int MV_W        = 16;
	localparam int SCALE_W     = 18;
	localparam int SCALE_FRAC  = 16;
	localparam int SUM_W       = $clog2(NUM_SAMPLES * ((1 << SAMPLE_W) - 1) + 1);
	localparam int PROD_W      = SUM_W + SCALE_W;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 3;

	localparam logic [1:0] STAGE_CC    = 2'd0;
	localparam logic [1:0] STAGE_CV    = 2'd1;
	localparam logic [1:0] STAGE_FLOAT = 2'd2;
	localparam logic [1:0] STAGE_DONE  = 2'd3;

	localparam logic [IDX_W-1:0] REG_CC_TARGET = 3'd0;
	localparam logic [IDX_W-1:0] REG_BULK_MV   = 3'd1;
	localparam logic [IDX_W-1:0] REG_TAPER_MA  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FLOAT_MV  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCALE     = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_STEP = 3'd5;
	localparam logic [IDX_W-1:0] REG_DUTY_MAX  = 3'd6;

	localparam logic [CUR_W-1:0]   RST_CC_TARGET = 14'd500;
	localparam logic [MV_W-1:0]    RST_BULK_MV   = 16'd14200;
	localparam logic [CUR_W-1:0]   RST_TAPER_MA  = 14'd200;
	localparam logic [MV_W-1:0]    RST_FLOAT_MV  = 16'd13200;
	localparam logic [SCALE_W-1:0] RST_SCALE     = 18'd216124;
	localparam logic [DUTY_W-1:0]  RST_DUTY_STEP = 14'd100;
	localparam logic [DUTY_W-1:0]  RST_DUTY_MAX  = 14'd10000;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [CUR_W-1:0]   cc_target_ma;
		logic [MV_W-1:0]    bulk_voltage_mv;
		logic [CUR_W-1:0]   taper_current_ma;
		logic [MV_W-1:0]    float_voltage_mv;
		logic [SCALE_W-1:0] code_to_mv_scale;
		logic [DUTY_W-1:0]  duty_step;
		logic [DUTY_W-1:0]  duty_max;
	} cfg_t;

	typedef struct packed {
		logic [MV_W-1:0]  bat_mv;
		logic [CUR_W-1:0] cur_ma;
		logic             button;
	} meas_t;

	typedef struct packed {
		logic [1:0]        stage;
		logic [DUTY_W-1:0] duty;
	} ctrl_st_t;

endpackage

[hdl/csc_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_regs
// APB configuration registers with read-back.
// ----------------------------------------------------------------------------
module csc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csc_pkg::ADDR_W-1:0]   paddr,
	input  logic [csc_pkg::DATA_W-1:0]   pwdata,
	output logic [csc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output csc_pkg::cfg_t                cfg
);
	import csc_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cc_target_ma     <= RST_CC_TARGET;
			cfg_q.bulk_voltage_mv  <= RST_BULK_MV;
			cfg_q.taper_current_ma <= RST_TAPER_MA;
			cfg_q.float_voltage_mv <= RST_FLOAT_MV;
			cfg_q.code_to_mv_scale <= RST_SCALE;
			cfg_q.duty_step        <= RST_DUTY_STEP;
			cfg_q.duty_max         <= RST_DUTY_MAX;
		end else if (wr_en) begin
			case (idx)
				REG_CC_TARGET: cfg_q.cc_target_ma     <= pwdata[CUR_W-1:0];
				REG_BULK_MV:   cfg_q.bulk_voltage_mv  <= pwdata[MV_W-1:0];
				REG_TAPER_MA:  cfg_q.taper_current_ma <= pwdata[CUR_W-1:0];
				REG_FLOAT_MV:  cfg_q.float_voltage_mv <= pwdata[MV_W-1:0];
				REG_SCALE:     cfg_q.code_to_mv_scale <= pwdata[SCALE_W-1:0];
				REG_DUTY_STEP: cfg_q.duty_step        <= pwdata[DUTY_W-1:0];
				REG_DUTY_MAX:  cfg_q.duty_max         <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CC_TARGET: prdata = DATA_W'(cfg_q.cc_target_ma);
			REG_BULK_MV:   prdata = DATA_W'(cfg_q.bulk_voltage_mv);
			REG_TAPER_MA:  prdata = DATA_W'(cfg_q.taper_current_ma);
			REG_FLOAT_MV:  prdata = DATA_W'(cfg_q.float_voltage_mv);
			REG_SCALE:     prdata = DATA_W'(cfg_q.code_to_mv_scale);
			REG_DUTY_STEP: prdata = DATA_W'(cfg_q.duty_step);
			REG_DUTY_MAX:  prdata = DATA_W'(cfg_q.duty_max);
			default:       prdata = '0;
		endcase
	end

endmodule

[hdl/csc_volt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_volt
// Sums the battery ADC codes and scales the sum to millivolts (Q16).
// ----------------------------------------------------------------------------
module csc_volt #(
	parameter int SAMPLES_PER_TICK = 5
) (
	input  csc_pkg::sample_t                     samples [csc_pkg::NUM_SAMPLES],
	input  logic [csc_pkg::SCALE_W-1:0]          scale,
	output logic [csc_pkg::MV_W-1:0]             bat_mv
);
	import csc_pkg::*;

	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;

	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_SAMPLES; i++) begin
			if (i < SAMPLES_PER_TICK)
				sum = sum + SUM_W'(samples[i]);
		end
	end

	assign prod = PROD_W'(sum) * PROD_W'(scale);

	// full-scale sum times full-scale factor stays below 2^16 mV
	assign bat_mv = MV_W'(prod[PROD_W-1:SCALE_FRAC]);

endmodule

[hdl/csc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ctrl
// Charge stage sequencer and duty stepper with clamp.
// ----------------------------------------------------------------------------
module csc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  csc_pkg::cfg_t     cfg,
	input  csc_pkg::meas_t    meas,
	output csc_pkg::ctrl_st_t cur,
	output csc_pkg::ctrl_st_t nxt
);
	import csc_pkg::*;

	logic [1:0]        stage_q;
	logic [DUTY_W-1:0] duty_q;
	logic              step_en;
	logic              step_dn;
	logic [DUTY_W:0]   up_sum;
	logic [DUTY_W-1:0] up_val;
	logic [DUTY_W-1:0] dn_raw;
	logic [DUTY_W-1:0] dn_val;

	assign up_sum = {1'b0, duty_q} + {1'b0, cfg.duty_step};
	assign up_val = (up_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max : up_sum[DUTY_W-1:0];
	assign dn_raw = (duty_q > cfg.duty_step) ? (duty_q - cfg.duty_step) : '0;
	assign dn_val = (dn_raw > cfg.duty_max) ? cfg.duty_max : dn_raw;

	always_comb begin
		step_en   = 1'b0;
		step_dn   = 1'b0;
		nxt.stage = stage_q;
		case (stage_q)
			STAGE_CC: begin
				if (meas.bat_mv < cfg.bulk_voltage_mv) begin
					step_en = 1'b1;
					step_dn = meas.cur_ma > cfg.cc_target_ma;
				end else begin
					nxt.stage = STAGE_CV;
				end
			end
			STAGE_CV: begin
				if (meas.cur_ma > cfg.taper_current_ma) begin
					step_en = 1'b1;
					step_dn = meas.bat_mv > cfg.bulk_voltage_mv;
				end else begin
					nxt.stage = STAGE_FLOAT;
				end
			end
			STAGE_FLOAT: begin
				if (!meas.button) begin
					step_en = 1'b1;
					step_dn = meas.bat_mv > cfg.float_voltage_mv;
				end else begin
					nxt.stage = STAGE_DONE;
				end
			end
			default: ;
		endcase
		nxt.duty = step_en ? (step_dn ? dn_val : up_val) : duty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STAGE_CC;
			duty_q  <= '0;
		end else if (en) begin
			stage_q <= nxt.stage;
			duty_q  <= nxt.duty;
		end
	end

	assign cur.stage = stage_q;
	assign cur.duty  = duty_q;

endmodule

[hdl/three_stage_charge_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_stage_charge_controller
// CC / CV / float battery charge controller, one control tick per transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  item     | item_valid / item_ready    | sample_first..fifth, current, button
//  result   | result_valid / result_ready| duty_level, charge_stage, battery_mv
//  config   | APB psel/penable/pready    | paddr, pwdata, prdata
//
//  One transaction per cycle while result_ready stays high; result_valid rises
//  after the input register, scaled voltage register and result register.
//  The stage/duty update is combinational in the last stage.
//  Stalls on result_ready fill bubbles first, then hold each stage in place.
//  No clearing pass after reset; item_ready is high from the first cycle.
// ----------------------------------------------------------------------------
module three_stage_charge_controller #(
	parameter int SAMPLES_PER_TICK = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [csc_pkg::ADDR_W-1:0] paddr,
	input  logic [csc_pkg::DATA_W-1:0] pwdata,
	output logic [csc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic [9:0]                 sample_first,
	input  logic [9:0]                 sample_second,
	input  logic [9:0]                 sample_third,
	input  logic [9:0]                 sample_fourth,
	input  logic [9:0]                 sample_fifth,
	input  logic [13:0]                output_current_ma,
	input  logic                       button_pressed,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [13:0]                duty_level,
	output logic [1:0]                 charge_stage,
	output logic [15:0]                battery_mv
);
	import csc_pkg::*;

	cfg_t              cfg;
	sample_t           samples_s1 [NUM_SAMPLES];
	logic [CUR_W-1:0]  cur_s1;
	logic              btn_s1;
	logic              v_s1;
	meas_t             meas_s2;
	logic              v_s2;
	logic [MV_W-1:0]   bat_mv;
	ctrl_st_t          st_cur;
	ctrl_st_t          st_nxt;
	ctrl_st_t          res_q;
	logic [MV_W-1:0]   bat_q;
	logic              res_v_q;
	logic              rdy_out;
	logic              rdy_s2;
	logic              ld_s1;
	logic              ld_s2;
	logic              ld_out;

	csc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign rdy_out    = !res_v_q || result_ready;
	assign rdy_s2     = !v_s2 || rdy_out;
	assign item_ready = !v_s1 || rdy_s2;
	assign ld_s1      = item_valid && item_ready;
	assign ld_s2      = v_s1 && rdy_s2;
	assign ld_out     = v_s2 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (item_ready)
				v_s1 <= item_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_out)
				res_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			samples_s1[0] <= sample_first;
			samples_s1[1] <= sample_second;
			samples_s1[2] <= sample_third;
			samples_s1[3] <= sample_fourth;
			samples_s1[4] <= sample_fifth;
			cur_s1        <= output_current_ma;
			btn_s1        <= button_pressed;
		end
		if (ld_s2) begin
			meas_s2.bat_mv <= bat_mv;
			meas_s2.cur_ma <= cur_s1;
			meas_s2.button <= btn_s1;
		end
		if (ld_out) begin
			res_q <= st_nxt;
			bat_q <= meas_s2.bat_mv;
		end
	end

	csc_volt #(
		.SAMPLES_PER_TICK (SAMPLES_PER_TICK)
	) u_volt (
		.samples (samples_s1),
		.scale   (cfg.code_to_mv_scale),
		.bat_mv  (bat_mv)
	);

	csc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (ld_out),
		.cfg    (cfg),
		.meas   (meas_s2),
		.cur    (st_cur),
		.nxt    (st_nxt)
	);

	assign result_valid = res_v_q;
	assign duty_level   = res_q.duty;
	assign charge_stage = res_q.stage;
	assign battery_mv   = bat_q;

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ld_out |=> $stable(st_cur.stage))
		else $error("stage changed without a tick");

	a_stage_seq: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> (st_cur.stage == $past(st_cur.stage)) ||
			(st_cur.stage == 2'($past(st_cur.stage) + 2'd1)))
		else $error("stage skipped");

	a_step_or_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> (st_cur.stage == $past(st_cur.stage)) ||
			(st_cur.duty == $past(st_cur.duty)))
		else $error("duty stepped on a stage change");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_cur.stage == STAGE_DONE) |=> (st_cur.stage == STAGE_DONE) && $stable(st_cur.duty))
		else $error("left done stage");

endmodule

[tb/charge_tick_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_tick_checker
// Watches the config port and both handshake channels of the charge
// controller. Tracks the registers from APB writes, predicts stage, duty and
// battery voltage for every accepted tick, and checks each result transaction
// in order against the oldest prediction. Register reads are checked too.
// ----------------------------------------------------------------------------
module charge_tick_checker #(
	parameter int SAMPLE_COUNT = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [csc_pkg::ADDR_W-1:0] paddr,
	input  logic [csc_pkg::DATA_W-1:0] pwdata,
	input  logic [csc_pkg::DATA_W-1:0] prdata,
	input  logic                       pready,
	input  logic                       item_valid,
	input  logic                       item_ready,
	input  logic [9:0]                 sample_first,
	input  logic [9:0]                 sample_second,
	input  logic [9:0]                 sample_third,
	input  logic [9:0]                 sample_fourth,
	input  logic [9:0]                 sample_fifth,
	input  logic [13:0]                output_current_ma,
	input  logic                       button_pressed,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  logic [13:0]                duty_level,
	input  logic [1:0]                 charge_stage,
	input  logic [15:0]                battery_mv,
	output int                         fail_count,
	output int                         pending
);

	import csc_pkg::*;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [1:0]        stage;
		logic [MV_W-1:0]   mv;
	} charge_result_t;

	charge_result_t                 charge_result_q[$];
	charge_result_t                 want;
	cfg_t                           cfg;
	logic [1:0]                     stage_now;
	logic [DUTY_W-1:0]              duty_now;
	logic [IDX_W-1:0]               reg_idx;
	logic [DATA_W-1:0]              reg_value;
	logic [SUM_W-1:0]               sample_sum;
	logic [PROD_W-1:0]              mv_full;
	logic [MV_W-1:0]                tick_mv;
	logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] samples_in;
	int                             results_seen;

	assign samples_in = {sample_fifth, sample_fourth, sample_third, sample_second,
		sample_first};

	task automatic report_mismatch(input string what, input int got, input int want_v);
		$display("mismatch after %0d results: %s got %0d expected %0d", results_seen,
			what, got, want_v);
		fail_count++;
	endtask

	// one duty step, clamped to [0, duty_max]
	function automatic logic [DUTY_W-1:0] next_duty(input logic up);
		logic [DUTY_W:0] v;
		if (up) begin
			v = {1'b0, duty_now} + {1'b0, cfg.duty_step};
		end else begin
			v = (duty_now > cfg.duty_step) ? {1'b0, duty_now - cfg.duty_step} : '0;
		end
		if (v > {1'b0, cfg.duty_max}) v = {1'b0, cfg.duty_max};
		return v[DUTY_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.cc_target_ma     = RST_CC_TARGET;
			cfg.bulk_voltage_mv  = RST_BULK_MV;
			cfg.taper_current_ma = RST_TAPER_MA;
			cfg.float_voltage_mv = RST_FLOAT_MV;
			cfg.code_to_mv_scale = RST_SCALE;
			cfg.duty_step        = RST_DUTY_STEP;
			cfg.duty_max         = RST_DUTY_MAX;
			stage_now = STAGE_CC;
			duty_now = '0;
			charge_result_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				reg_idx = paddr[ADDR_W-1:2];
				if (pwrite) begin
					case (reg_idx)
						REG_CC_TARGET: cfg.cc_target_ma     = pwdata[CUR_W-1:0];
						REG_BULK_MV:   cfg.bulk_voltage_mv  = pwdata[MV_W-1:0];
						REG_TAPER_MA:  cfg.taper_current_ma = pwdata[CUR_W-1:0];
						REG_FLOAT_MV:  cfg.float_voltage_mv = pwdata[MV_W-1:0];
						REG_SCALE:     cfg.code_to_mv_scale = pwdata[SCALE_W-1:0];
						REG_DUTY_STEP: cfg.duty_step        = pwdata[DUTY_W-1:0];
						REG_DUTY_MAX:  cfg.duty_max         = pwdata[DUTY_W-1:0];
						default: ;
					endcase
				end else if (reg_idx <= REG_DUTY_MAX) begin
					case (reg_idx)
						REG_CC_TARGET: reg_value = DATA_W'(cfg.cc_target_ma);
						REG_BULK_MV:   reg_value = DATA_W'(cfg.bulk_voltage_mv);
						REG_TAPER_MA:  reg_value = DATA_W'(cfg.taper_current_ma);
						REG_FLOAT_MV:  reg_value = DATA_W'(cfg.float_voltage_mv);
						REG_SCALE:     reg_value = DATA_W'(cfg.code_to_mv_scale);
						REG_DUTY_STEP: reg_value = DATA_W'(cfg.duty_step);
						default:       reg_value = DATA_W'(cfg.duty_max);
					endcase
					if (prdata !== reg_value) begin
						report_mismatch($sformatf("prdata of register %0d", reg_idx),
							int'(prdata), int'(reg_value));
					end
				end
			end

			if (item_valid && item_ready) begin
				sample_sum = '0;
				for (int i = 0; i < SAMPLE_COUNT && i < NUM_SAMPLES; i++)
					sample_sum += SUM_W'(samples_in[i]);
				mv_full = (PROD_W'(sample_sum) * PROD_W'(cfg.code_to_mv_scale)) >> SCALE_FRAC;
				tick_mv = (mv_full > PROD_W'(16'hFFFF)) ? '1 : mv_full[MV_W-1:0];
				case (stage_now)
					STAGE_CC: begin
						if (tick_mv < cfg.bulk_voltage_mv)
							duty_now = next_duty(output_current_ma <= cfg.cc_target_ma);
						else
							stage_now = STAGE_CV;
					end
					STAGE_CV: begin
						if (output_current_ma > cfg.taper_current_ma)
							duty_now = next_duty(tick_mv <= cfg.bulk_voltage_mv);
						else
							stage_now = STAGE_FLOAT;
					end
					STAGE_FLOAT: begin
						if (!button_pressed)
							duty_now = next_duty(tick_mv <= cfg.float_voltage_mv);
						else
							stage_now = STAGE_DONE;
					end
					default: ;
				endcase
				charge_result_q.push_back('{duty: duty_now, stage: stage_now, mv: tick_mv});
				pending++;
			end

			if (result_valid && result_ready) begin
				results_seen++;
				if (charge_result_q.size() == 0) begin
					report_mismatch("result with no tick outstanding, duty_level",
						int'(duty_level), 0);
				end else begin
					want = charge_result_q.pop_front();
					pending--;
					if (duty_level !== want.duty)
						report_mismatch("duty_level", int'(duty_level), int'(want.duty));
					if (charge_stage !== want.stage)
						report_mismatch("charge_stage", int'(charge_stage), int'(want.stage));
					if (battery_mv !== want.mv)
						report_mismatch("battery_mv", int'(battery_mv), int'(want.mv));
				end
			end
		end
	end

endmodule

[tb/tb_three_stage_charge_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_stage_charge_controller
// Walks the controller once through constant current, constant voltage, float
// and done, reprogramming the registers between batches of random ticks while
// both channels idle at random (but for one quiet batch). The checker predicts
// and compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_three_stage_charge_controller;

	import csc_pkg::*;

	localparam int               SAMPLES     = 5;
	localparam int               CYCLE_LIMIT = 200000;
	localparam logic [IDX_W-1:0] REG_UNUSED  = 3'd7;

	typedef struct packed {
		logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] samples;
		logic [CUR_W-1:0]                     cur;
		logic                                 button;
	} tick_t;

	logic              clk;
	logic              arst_n            = 1'b0;
	logic              psel              = 1'b0;
	logic              penable           = 1'b0;
	logic              pwrite            = 1'b0;
	logic [ADDR_W-1:0] paddr             = '0;
	logic [DATA_W-1:0] pwdata            = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid        = 1'b0;
	logic              item_ready;
	logic [9:0]        sample_first      = '0;
	logic [9:0]        sample_second     = '0;
	logic [9:0]        sample_third      = '0;
	logic [9:0]        sample_fourth     = '0;
	logic [9:0]        sample_fifth      = '0;
	logic [13:0]       output_current_ma = '0;
	logic              button_pressed    = 1'b0;
	logic              result_valid;
	logic              result_ready      = 1'b0;
	logic [13:0]       duty_level;
	logic [1:0]        charge_stage;
	logic [15:0]       battery_mv;
	int                fail_count;
	int                pending;
	int                cycle_count       = 0;
	logic              quiet             = 1'b0;
	int                cc_target;
	int                taper;

	three_stage_charge_controller #(.SAMPLES_PER_TICK(SAMPLES)) i_dut (.*);

	charge_tick_checker #(.SAMPLE_COUNT(SAMPLES)) i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk)
		result_ready <= quiet || ($urandom_range(99) >= 7);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic apb_access(input logic write, input logic [IDX_W-1:0] idx,
		input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		apb_access(1'b1, idx, DATA_W'(value));
	endtask

	task automatic send_tick(input tick_t t);
		if (!quiet && $urandom_range(99) < 7) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		sample_first <= t.samples[0];
		sample_second <= t.samples[1];
		sample_third <= t.samples[2];
		sample_fourth <= t.samples[3];
		sample_fifth <= t.samples[4];
		output_current_ma <= t.cur;
		button_pressed <= t.button;
		do @(posedge clk); while (!item_ready);
	endtask

	// samples chosen so their sum is exact; with a unity scale this is the mV value
	function automatic tick_t exact_sum(input int sum, input int cur, input logic button);
		tick_t t;
		for (int i = 0; i < NUM_SAMPLES; i++)
			t.samples[i] = SAMPLE_W'(sum / NUM_SAMPLES + ((i < sum % NUM_SAMPLES) ? 1 : 0));
		t.cur = CUR_W'(cur);
		t.button = button;
		return t;
	endfunction

	task automatic send_batch(input int n, input int s_lo, input int s_hi, input int c_lo,
		input int c_hi, input logic btn_random);
		tick_t t;
		repeat (n) begin
			for (int i = 0; i < NUM_SAMPLES; i++)
				t.samples[i] = SAMPLE_W'($urandom_range(s_hi, s_lo));
			t.cur = CUR_W'($urandom_range(c_hi, c_lo));
			t.button = btn_random ? 1'($urandom_range(1)) : 1'b0;
			send_tick(t);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 8; i++)
			apb_access(1'b0, i[IDX_W-1:0], '0);

		// constant current, reset settings
		send_tick(exact_sum(0, 0, 1'b0));
		send_tick(exact_sum(0, 16383, 1'b1));
		send_tick(exact_sum(0, 16383, 1'b0));
		send_tick(exact_sum(4000, 500, 1'b0));
		send_tick(exact_sum(4000, 501, 1'b0));
		drain();

		// bulk out of reach keeps the block in constant current
		write_reg(REG_SCALE, 65536);
		write_reg(REG_BULK_MV, 65535);
		write_reg(REG_DUTY_STEP, 10000);
		write_reg(REG_DUTY_MAX, 10000);
		write_reg(REG_CC_TARGET, 16383);
		write_reg(REG_UNUSED, -1);
		for (int i = 0; i < 8; i++)
			apb_access(1'b0, i[IDX_W-1:0], '0);
		send_tick(exact_sum(5115, 0, 1'b0));
		send_tick(exact_sum(5115, 0, 1'b1));
		send_batch(30, 0, 1023, 0, 16383, 1'b1);
		drain();
		write_reg(REG_CC_TARGET, 0);
		send_tick(exact_sum(0, 0, 1'b0));
		send_tick(exact_sum(1023, 1, 1'b0));
		send_batch(30, 0, 1023, 0, 16383, 1'b1);
		drain();
		write_reg(REG_DUTY_STEP, 0);
		write_reg(REG_DUTY_MAX, 0);
		send_batch(20, 0, 1023, 0, 16383, 1'b1);
		drain();
		cc_target = $urandom_range(16000, 300);
		write_reg(REG_CC_TARGET, cc_target);
		write_reg(REG_DUTY_STEP, $urandom_range(2000, 1));
		write_reg(REG_DUTY_MAX, $urandom_range(10000, 2000));
		write_reg(REG_SCALE, 262143);
		send_batch(25, 0, 1023, cc_target - 40, cc_target + 40, 1'b1);
		send_batch(25, 0, 1023, 0, 16383, 1'b1);
		drain();
		write_reg(REG_DUTY_MAX, 1000);
		write_reg(REG_DUTY_STEP, 7);
		write_reg(REG_SCALE, 0);
		send_batch(30, 0, 1023, 0, 16383, 1'b1);
		drain();

		// battery reaching bulk ends constant current
		write_reg(REG_SCALE, 65536);
		write_reg(REG_BULK_MV, 3000);
		write_reg(REG_DUTY_STEP, 100);
		write_reg(REG_DUTY_MAX, 10000);
		send_tick(exact_sum(2999, $urandom_range(16383), 1'b0));
		send_tick(exact_sum(3000, $urandom_range(16383), 1'b0));
		drain();

		// constant voltage
		write_reg(REG_TAPER_MA, 0);
		send_tick(exact_sum(3000, 1, 1'b0));
		send_tick(exact_sum(3001, 16383, 1'b1));
		send_batch(50, 500, 700, 1, 16383, 1'b1);
		drain();
		taper = $urandom_range(4000, 100);
		write_reg(REG_TAPER_MA, taper);
		write_reg(REG_BULK_MV, $urandom_range(16000, 8000));
		write_reg(REG_SCALE, 216124);
		write_reg(REG_DUTY_STEP, $urandom_range(500, 1));
		write_reg(REG_DUTY_MAX, $urandom_range(10000, 5000));
		quiet = 1'b1;
		send_batch(80, 0, 1023, taper + 1, 16383, 1'b1);
		drain();
		quiet = 1'b0;
		write_reg(REG_TAPER_MA, 16383);
		send_tick(exact_sum($urandom_range(5115), 16383, 1'b0));
		drain();

		// float
		write_reg(REG_FLOAT_MV, 0);
		write_reg(REG_SCALE, $urandom_range(262143));
		write_reg(REG_DUTY_STEP, $urandom_range(3000, 1));
		send_batch(30, 0, 1023, 0, 16383, 1'b0);
		drain();
		write_reg(REG_FLOAT_MV, 65535);
		write_reg(REG_DUTY_STEP, 10000);
		write_reg(REG_DUTY_MAX, 10000);
		send_batch(20, 0, 1023, 0, 16383, 1'b0);
		drain();
		write_reg(REG_SCALE, 65536);
		write_reg(REG_FLOAT_MV, 2500);
		write_reg(REG_DUTY_STEP, 30);
		write_reg(REG_DUTY_MAX, $urandom_range(9000, 3000));
		send_tick(exact_sum(2500, $urandom_range(16383), 1'b0));
		send_tick(exact_sum(2501, $urandom_range(16383), 1'b0));
		send_batch(60, 400, 600, 0, 16383, 1'b0);
		drain();
		write_reg(REG_SCALE, 216124);
		write_reg(REG_FLOAT_MV, 13200);
		write_reg(REG_DUTY_STEP, 100);
		write_reg(REG_DUTY_MAX, 10000);
		send_batch(60, 0, 1023, 0, 16383, 1'b0);
		send_tick(exact_sum($urandom_range(5115), $urandom_range(16383), 1'b1));
		drain();

		// done holds stage and duty whatever comes
		write_reg(REG_DUTY_MAX, 0);
		write_reg(REG_DUTY_STEP, 10000);
		send_batch(40, 0, 1023, 0, 16383, 1'b1);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
hdl/csc_pkg.sv
hdl/csc_regs.sv
hdl/csc_volt.sv
hdl/csc_ctrl.sv
hdl/three_stage_charge_controller.sv
tb/charge_tick_checker.sv
tb/tb_three_stage_charge_controller.sv
